@@ hdl/assert_macros.svh @@
// Assertion macros shared by the trimmed mean filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define IRDTM_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("irdtm: same-cycle check failed");
// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define IRDTM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("irdtm: next-cycle check failed");
`else
`define IRDTM_ASSERT_IMPL(lbl, ante, cons)
`define IRDTM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hdl/irdtm_pkg.sv @@
// Types and constants shared by the trimmed mean filter controller and datapath.
`default_nettype none

package irdtm_pkg;

	// Field widths.
	localparam int RAW_W    = 12;
	localparam int SQ_W     = 2 * RAW_W;
	localparam int DIST_W   = 16;
	localparam int QUAD_Q_W = 33;
	localparam int LIN_Q_W  = 14;
	localparam int MEAN_W   = 20;
	localparam int TOTAL_W  = 35;

	// Conversion constants: K0 and the quadratic numerator in Q16, LIN_COEF whole.
	localparam logic [18:0] K0_Q16      = 19'd295706;
	localparam logic [13:0] LIN_COEF    = 14'd13846;
	// 53529000 scaled by 2^16.
	localparam logic [41:0] QUAD_NUM    = 42'd3508076544000;
	localparam logic [DIST_W-1:0] DIST_MAX = 16'hFFFF;

	// Iteration count of the two long divisions and step count of the mean stage.
	localparam int DIV_STEPS  = QUAD_Q_W;
	localparam int MEAN_STEPS = 1;
	localparam int STEP_W     = 6;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic combine;
		logic accum;
		logic trim;
		logic mstep;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic grp_full;
	} sts_t;

endpackage

`default_nettype wire

@@ hdl/irdtm_datapath.sv @@
// Datapath of the trimmed mean filter: distance conversion, group statistics, mean division.
`default_nettype none

module irdtm_datapath #(
	parameter int SAMPLES = 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [irdtm_pkg::RAW_W-1:0]     raw_sample,
	input  wire irdtm_pkg::cmd_t                 cmd,
	output irdtm_pkg::sts_t                      sts,
	output logic      [irdtm_pkg::MEAN_W-1:0]    avg_distance_q4,
	output logic                                 any_saturated
);

	localparam int CNT_W = $clog2(SAMPLES);
	localparam int SUM_W = irdtm_pkg::DIST_W + $clog2(SAMPLES);
	localparam int RAW_W = irdtm_pkg::RAW_W;
	localparam int SQ_W  = irdtm_pkg::SQ_W;
	localparam int QW    = irdtm_pkg::QUAD_Q_W;
	localparam int LW    = irdtm_pkg::LIN_Q_W;
	localparam int MW    = irdtm_pkg::MEAN_W;
	localparam int TW    = irdtm_pkg::TOTAL_W;
	localparam int DW    = irdtm_pkg::DIST_W;
	localparam logic [SQ_W-1:0] QUAD_HI = SQ_W'(irdtm_pkg::QUAD_NUM[41:QW]);
	// The mean numerator (trimmed sum with 4 fraction bits) stays below 2^24 for
	// groups of up to 16 samples; the rounded-up reciprocal is then exact.
	localparam int NUM_W  = 24;
	localparam int RCP_W  = 26;
	localparam int PROD_W = NUM_W + RCP_W;
	localparam int MEAN_D = SAMPLES - 2;
	localparam int MEAN_K = NUM_W + $clog2(MEAN_D);
	localparam logic [RCP_W-1:0] MEAN_RCP =
		RCP_W'(((64'd1 << MEAN_K) + 64'(MEAN_D) - 64'd1) / 64'(MEAN_D));

	// Operand registers.
	logic [RAW_W-1:0] raw_q;
	logic [SQ_W-1:0]  sq_q;
	logic             zero_q;

	// Quadratic term divider: constant numerator over raw squared.
	logic [SQ_W-1:0]  q_rem_q;
	logic [QW-1:0]    q_num_q;
	logic [QW-1:0]    quad_q;
	logic [SQ_W:0]    q_cand;
	logic             q_ge;

	// Linear term divider: constant numerator over raw.
	logic [RAW_W-1:0] l_rem_q;
	logic [QW-1:0]    l_num_q;
	logic [LW-1:0]    lin_q;
	logic [RAW_W:0]   l_cand;
	logic             l_ge;

	// Distance of the current sample.
	logic [TW-1:0]    total;
	logic             total_neg;
	logic             dist_sat;
	logic [DW-1:0]    dist_next;
	logic [DW-1:0]    dist_q;
	logic             dsat_q;

	// Group statistics.
	logic [SUM_W-1:0] sum_q;
	logic [DW-1:0]    min_q;
	logic [DW-1:0]    max_q;
	logic [CNT_W-1:0] cnt_q;
	logic             sat_seen_q;
	logic [SUM_W-1:0] trimmed;

	// Mean by the constant SAMPLES - 2.
	logic [NUM_W-1:0]  m_num_q;
	logic [PROD_W-1:0] m_prod;
	logic [MW-1:0]     mean_q;
	logic              m_sat_q;

	// Output payload.
	logic [MW-1:0]    avg_q;
	logic             any_sat_q;

	// One restoring step of each division.
	assign q_cand = {q_rem_q, q_num_q[QW-1]};
	assign q_ge   = q_cand >= {1'b0, sq_q};
	assign l_cand = {l_rem_q, l_num_q[QW-1]};
	assign l_ge   = l_cand >= {1'b0, raw_q};

	// Multiplication by the reciprocal of SAMPLES - 2.
	assign m_prod = PROD_W'(m_num_q) * PROD_W'(MEAN_RCP);

	// Combine the Q16 terms and clamp to the distance range.
	always_comb begin
		total     = TW'(irdtm_pkg::K0_Q16) + TW'(quad_q) - TW'({lin_q, 16'h0000});
		total_neg = total[TW-1];
		dist_sat  = zero_q || (sq_q <= QUAD_HI) || (!total_neg && (|total[TW-2:32]));
		if (dist_sat) begin
			dist_next = irdtm_pkg::DIST_MAX;
		end else if (total_neg) begin
			dist_next = '0;
		end else begin
			dist_next = total[31:16];
		end
	end

	assign trimmed = sum_q - SUM_W'(min_q) - SUM_W'(max_q);

	// Division and conversion registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			raw_q   <= raw_sample;
			sq_q    <= {{RAW_W{1'b0}}, raw_sample} * {{RAW_W{1'b0}}, raw_sample};
			zero_q  <= (raw_sample == '0);
			q_rem_q <= SQ_W'(irdtm_pkg::QUAD_NUM[41:QW]);
			q_num_q <= irdtm_pkg::QUAD_NUM[QW-1:0];
			l_rem_q <= '0;
			l_num_q <= QW'(irdtm_pkg::LIN_COEF);
			lin_q   <= '0;
		end
		if (cmd.step) begin
			q_rem_q <= q_ge ? SQ_W'(q_cand - {1'b0, sq_q}) : q_cand[SQ_W-1:0];
			q_num_q <= {q_num_q[QW-2:0], 1'b0};
			quad_q  <= {quad_q[QW-2:0], q_ge};
			l_rem_q <= l_ge ? RAW_W'(l_cand - {1'b0, raw_q}) : l_cand[RAW_W-1:0];
			l_num_q <= {l_num_q[QW-2:0], 1'b0};
			lin_q   <= {lin_q[LW-2:0], l_ge};
		end
		if (cmd.combine) begin
			dist_q <= dist_next;
			dsat_q <= dist_sat;
		end
		if (cmd.trim) begin
			m_num_q <= NUM_W'({trimmed, 4'h0});
			m_sat_q <= sat_seen_q;
		end
		if (cmd.mstep) begin
			mean_q <= m_prod[MEAN_K+MW-1:MEAN_K];
		end
		if (cmd.emit) begin
			avg_q     <= mean_q;
			any_sat_q <= m_sat_q;
		end
	end

	// Running group statistics, cleared when the group is trimmed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q      <= '0;
			min_q      <= irdtm_pkg::DIST_MAX;
			max_q      <= '0;
			cnt_q      <= '0;
			sat_seen_q <= 1'b0;
		end else if (cmd.trim) begin
			sum_q      <= '0;
			min_q      <= irdtm_pkg::DIST_MAX;
			max_q      <= '0;
			cnt_q      <= '0;
			sat_seen_q <= 1'b0;
		end else if (cmd.accum) begin
			sum_q      <= sum_q + SUM_W'(dist_q);
			min_q      <= (dist_q < min_q) ? dist_q : min_q;
			max_q      <= (dist_q > max_q) ? dist_q : max_q;
			cnt_q      <= cnt_q + CNT_W'(1);
			sat_seen_q <= sat_seen_q | dsat_q;
		end
	end

	assign sts.grp_full    = (cnt_q == CNT_W'(SAMPLES - 1));
	assign avg_distance_q4 = avg_q;
	assign any_saturated   = any_sat_q;

endmodule

`default_nettype wire

@@ hdl/irdtm_ctrl.sv @@
// Controller of the trimmed mean filter: sequences conversion, accumulation and output.
`default_nettype none

module irdtm_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              out_stall,
	input  wire irdtm_pkg::sts_t   sts,
	output irdtm_pkg::cmd_t        cmd,
	output logic                   in_stall,
	output logic                   out_valid
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_COMB,
		ST_ACC,
		ST_TRIM,
		ST_MEAN,
		ST_EMIT
	} state_t;

	state_t                           state_q;
	logic [irdtm_pkg::STEP_W-1:0]     step_q;
	logic                             out_valid_q;
	logic                             out_free;

	// The output register can take a result when empty or when its transfer completes.
	assign out_free = !out_valid_q || !out_stall;

	// Commands decoded from the current state.
	always_comb begin
		cmd         = '0;
		cmd.load    = (state_q == ST_IDLE) && in_valid;
		cmd.step    = (state_q == ST_DIV);
		cmd.combine = (state_q == ST_COMB);
		cmd.accum   = (state_q == ST_ACC);
		cmd.trim    = (state_q == ST_TRIM);
		cmd.mstep   = (state_q == ST_MEAN);
		cmd.emit    = (state_q == ST_EMIT) && out_free;
	end

	// State, step counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (in_valid) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_q == irdtm_pkg::STEP_W'(irdtm_pkg::DIV_STEPS - 1)) begin
						step_q  <= '0;
						state_q <= ST_COMB;
					end else begin
						step_q <= step_q + irdtm_pkg::STEP_W'(1);
					end
				end
				ST_COMB: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					state_q <= sts.grp_full ? ST_TRIM : ST_IDLE;
				end
				ST_TRIM: begin
					step_q  <= '0;
					state_q <= ST_MEAN;
				end
				ST_MEAN: begin
					if (step_q == irdtm_pkg::STEP_W'(irdtm_pkg::MEAN_STEPS - 1)) begin
						step_q  <= '0;
						state_q <= ST_EMIT;
					end else begin
						step_q <= step_q + irdtm_pkg::STEP_W'(1);
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ hdl/ir_distance_trimmed_mean_unit.sv @@
// IR distance trimmed mean filter: usage notes.
// Input channel: raw_sample with in_valid / in_stall; a transfer happens at a clock
// edge with in_valid high and in_stall low. Each reading is converted to a whole
// distance by two bit-serial restoring divisions (quadratic and linear terms) that
// share one 33-step iteration; that iteration sets the rate.
// After each transfer in_stall stays high through the division steps, combine and
// accumulate, so the block takes no new item until the current one is through.
// After every SAMPLES-th item the block trims the group and divides by SAMPLES - 2
// with one reciprocal multiplication; it then loads the result into the output
// register and returns to idle, where the next item can be taken.
// Output channel: avg_distance_q4 and any_saturated with out_valid / out_stall.
// A result waits in the output register while out_stall is high; if a new result
// is ready before the old one has gone, the block holds it and keeps in_stall high.
// Reset (arst_n low) clears the group statistics and drops out_valid; a partly
// collected group is lost.
`default_nettype none
`include "assert_macros.svh"

module ir_distance_trimmed_mean_unit #(
	parameter int SAMPLES = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [irdtm_pkg::RAW_W-1:0]   raw_sample,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [irdtm_pkg::MEAN_W-1:0]  avg_distance_q4,
	output logic                               any_saturated
);

	irdtm_pkg::cmd_t cmd;
	irdtm_pkg::sts_t sts;
	logic [6:0]      cmd_bits;

	// Sequencer.
	irdtm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	// Arithmetic and group state.
	irdtm_datapath #(
		.SAMPLES (SAMPLES)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.raw_sample      (raw_sample),
		.cmd             (cmd),
		.sts             (sts),
		.avg_distance_q4 (avg_distance_q4),
		.any_saturated   (any_saturated)
	);

	assign cmd_bits = cmd;

	// The block is busy on the cycle after it takes an item.
	`IRDTM_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)
	// The controller issues at most one command per cycle.
	`IRDTM_ASSERT_IMPL(a_one_cmd, 1'b1, $onehot0(cmd_bits))
	// A new result never overwrites one that is still waiting.
	`IRDTM_ASSERT_IMPL(a_no_overwrite, cmd.emit, !out_valid || !out_stall)
	// A loaded result is offered on the next cycle.
	`IRDTM_ASSERT_NEXT(a_emit_shows, cmd.emit, out_valid)

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for ir_distance_trimmed_mean_unit with a trimmed mean scoreboard.
`timescale 1ns / 100ps

module tb;
	localparam int RAW_W  = irdtm_pkg::RAW_W;
	localparam int MEAN_W = irdtm_pkg::MEAN_W;

	localparam int GROUP_LEN   = 8;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int ITEMS_PER_PHASE = 432;
	localparam int DRAIN_CYCLES = 60;

	// One trimmed mean as it should leave the block.
	typedef struct packed {
		logic [MEAN_W-1:0] mean_q4;
		logic              saturated;
	} mean_result_t;

	// Tracks the group statistics and holds the means still to come.
	class trimmed_mean_scoreboard;
		localparam longint unsigned OFFSET_Q16 = 64'd295706;
		localparam longint unsigned LINEAR_K   = 64'd13846;
		localparam longint unsigned SQUARE_K   = 64'd53529000;
		localparam longint unsigned DIST_CLAMP = 64'd65535;

		int            group_len;
		logic [20:0]   run_sum;
		logic [15:0]   run_min;
		logic [15:0]   run_max;
		logic [4:0]    run_count;
		logic          run_sat;
		mean_result_t  pending_means[$];
		int            errors;

		function new(int len);
			group_len = len;
			errors    = 0;
			clear_group();
		endfunction

		function void clear_group();
			run_sum   = '0;
			run_min   = 16'hFFFF;
			run_max   = '0;
			run_count = '0;
			run_sat   = 1'b0;
		endfunction

		// Whole distance of one reading, computed in Q16; a zero reading counts as saturated.
		function logic [15:0] distance_of(input logic [RAW_W-1:0] raw, output logic sat);
			longint unsigned sq;
			longint unsigned quad;
			longint unsigned lin;
			longint          total;
			longint unsigned whole;
			sat = 1'b0;
			if (raw == '0) begin
				sat = 1'b1;
				return 16'hFFFF;
			end
			sq    = longint'(raw) * longint'(raw);
			quad  = (SQUARE_K << 16) / sq;
			lin   = (LINEAR_K / longint'(raw)) << 16;
			total = longint'(OFFSET_Q16) + longint'(quad) - longint'(lin);
			if (total < 0)
				return 16'd0;
			whole = longint'(total) >> 16;
			if (whole > DIST_CLAMP) begin
				sat = 1'b1;
				return 16'hFFFF;
			end
			return whole[15:0];
		endfunction

		// Called for every accepted reading; queues a mean at the end of a group.
		function void note_sample(input logic [RAW_W-1:0] raw);
			logic [15:0]     samp_dist;
			logic            sat;
			longint unsigned trimmed;
			longint unsigned mean;
			mean_result_t    res;
			samp_dist = distance_of(raw, sat);
			run_sum = run_sum + 21'(samp_dist);
			if (samp_dist < run_min)
				run_min = samp_dist;
			if (samp_dist > run_max)
				run_max = samp_dist;
			if (sat)
				run_sat = 1'b1;
			run_count = run_count + 5'd1;
			if (int'(run_count) >= group_len) begin
				trimmed = longint'(run_sum) - longint'(run_min) - longint'(run_max);
				mean = (trimmed << 4) / longint'(group_len - 2);
				res.mean_q4   = mean[MEAN_W-1:0];
				res.saturated = run_sat;
				pending_means.push_back(res);
				clear_group();
			end
		endfunction

		// Compares one output transfer with the oldest pending mean.
		function void check_result(input logic [MEAN_W-1:0] mean_q4, input logic sat);
			mean_result_t exp_res;
			if (pending_means.size() == 0) begin
				$display("%0t: unexpected result mean %0d saturated %0b", $time, mean_q4, sat);
				errors++;
				return;
			end
			exp_res = pending_means.pop_front();
			if (mean_q4 !== exp_res.mean_q4) begin
				$display("%0t: avg_distance_q4 expected %0d actual %0d",
					$time, exp_res.mean_q4, mean_q4);
				errors++;
			end
			if (sat !== exp_res.saturated) begin
				$display("%0t: any_saturated expected %0b actual %0b",
					$time, exp_res.saturated, sat);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [RAW_W-1:0]  raw_sample = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [MEAN_W-1:0] avg_distance_q4;
	logic              any_saturated;

	trimmed_mean_scoreboard sb;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int stall_burst = 0;
	int cycle_count = 0;

	ir_distance_trimmed_mean_unit #(
		.SAMPLES(GROUP_LEN)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.raw_sample     (raw_sample),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.avg_distance_q4(avg_distance_q4),
		.any_saturated  (any_saturated)
	);

	always #10 clk = ~clk;

	// Receiver: random stalls, with occasional long bursts to back up the output register.
	always @(posedge clk) begin
		if (stall_burst > 0) begin
			out_stall <= 1'b1;
			stall_burst <= stall_burst - 1;
		end else if (receiver_stall_pct > 0 && $urandom_range(0, 199) == 0) begin
			out_stall <= 1'b1;
			stall_burst <= $urandom_range(20, 200);
		end else begin
			out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
		end
	end

	// Output monitor: every output transfer is checked against the scoreboard.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(avg_distance_q4, any_saturated);
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("ir_distance_trimmed_mean_unit regression: fail");
			$finish;
		end
	end

	// Presents one reading and returns at the edge where the transfer happens.
	task automatic send_sample(input logic [RAW_W-1:0] raw);
		in_valid   <= 1'b1;
		raw_sample <= raw;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_sample(raw);
	endtask

	// Drops valid for a random gap, long enough to land on any phase of an item.
	task automatic sender_gap();
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 70))
				@(posedge clk);
		end
	endtask

	// Readings skewed toward zero, the saturating range and the far end.
	function automatic logic [RAW_W-1:0] pick_raw();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 5)
			return '0;
		else if (sel < 15)
			return RAW_W'($urandom_range(1, 40));
		else if (sel < 25)
			return RAW_W'($urandom_range(4000, 4095));
		return RAW_W'($urandom_range(0, 4095));
	endfunction

	logic [RAW_W-1:0] directed_raw[24] = '{
		// Group of zero readings: every distance saturates, largest possible mean.
		12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0,
		// Around the saturation threshold plus both ends of the range.
		12'd1, 12'd28, 12'd29, 12'd30, 12'd4095, 12'hAAA, 12'h555, 12'd2048,
		// Far readings with a repeated minimum distance and a single maximum distance.
		12'd4095, 12'd4094, 12'd4093, 12'd4095, 12'd3000, 12'd4095, 12'd4000, 12'd4095
	};

	initial begin
		sb = new(GROUP_LEN);
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;

		// Directed readings with no idling on either side.
		foreach (directed_raw[k])
			send_sample(directed_raw[k]);

		// Random phases: none, sender idle, receiver stalling, both.
		for (int phase = 0; phase < 4; phase++) begin
			unique case (phase)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 45;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 45;
				end
				default: begin
					sender_idle_pct = 20;
					receiver_stall_pct = 20;
				end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				send_sample(pick_raw());
				sender_gap();
			end
		end
		in_valid <= 1'b0;

		// Drain the remaining means, then let the block settle.
		while (sb.pending_means.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		if (sb.errors == 0)
			$display("ir_distance_trimmed_mean_unit regression: pass");
		else
			$display("ir_distance_trimmed_mean_unit regression: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/irdtm_pkg.sv
hdl/irdtm_datapath.sv
hdl/irdtm_ctrl.sv
hdl/ir_distance_trimmed_mean_unit.sv
verif/tb.sv
